// ===== hw/rtl/eph_pkg.sv =====
package eph_pkg;

  // Result status codes.
  localparam logic [1:0] ST_WORK    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TURN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_TURN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_EPS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EASE_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EASE_STEP  = 3'd5;

  // Register values after reset.
  localparam logic [29:0] RST_HALF_TURN  = 30'd262144;
  localparam logic [29:0] RST_FULL_TURN  = 30'd524288;
  localparam logic [31:0] RST_TIMEOUT_MS = 32'd50000;
  localparam logic [29:0] RST_ARRIVE_EPS = 30'd3277;
  localparam logic [15:0] RST_EASE_MAX   = 16'd5243;
  localparam logic [12:0] RST_EASE_STEP  = 13'd328;

  localparam logic [15:0] EASE_SAT = 16'hFFFF;
  localparam int PROD_W = 50;

  typedef struct packed {
    logic [29:0] half_turn;
    logic [29:0] full_turn;
    logic [31:0] timeout_ms;
    logic [29:0] arrive_eps;
    logic [15:0] ease_max;
    logic [12:0] ease_step;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] target_position;
    logic [31:0] feedback_position;
    logic [7:0]  node_id;
    logic [1:0]  axis;
  } item_t;

  // Decision stage to multiply stage.
  typedef struct packed {
    logic [1:0]  status;
    logic        cmd_valid;
    logic        is_move;
    logic [31:0] fixed_pos;
    logic [32:0] err;
    logic [15:0] ease;
    logic [31:0] fb;
    logic [7:0]  node;
  } mid_t;

  // Multiply stage to output stage.
  typedef struct packed {
    logic [1:0]        status;
    logic              cmd_valid;
    logic              is_move;
    logic [31:0]       fixed_pos;
    logic [PROD_W-1:0] prod;
    logic [31:0]       fb;
    logic [7:0]        node;
  } prod_t;

  typedef struct packed {
    logic [7:0]  command_node;
    logic [31:0] command_position;
    logic        command_valid;
    logic [1:0]  status;
  } res_t;

endpackage

// ===== hw/rtl/eph_ctx.sv =====
module eph_ctx #(
  parameter int AXES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  eph_pkg::cfg_t  cfg_i,
  input  logic           item_vld_i,
  input  eph_pkg::item_t item_i,
  output logic           item_rdy_o,
  output logic           mid_vld_o,
  output eph_pkg::mid_t  mid_o,
  input  logic           mid_rdy_i
);
  import eph_pkg::*;

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  logic        armed_r [AXES];
  logic [15:0] ease_r [AXES];
  logic [31:0] start_r [AXES];
  logic [31:0] ep_r [AXES];

  logic        mid_vld_r;
  mid_t        mid_r, mid_nxt;
  logic        proc;
  logic [AW-1:0] idx;
  logic        in_range;

  logic signed [32:0] diff, err;
  logic [32:0] abs_diff, abs_err;
  logic        far;
  logic signed [33:0] ep_wide;
  logic [31:0] ep_sat;
  logic [31:0] elapsed;
  logic        timed_out, arrived;
  logic [16:0] ease_sum;
  logic [15:0] ease_new;
  logic        cur_armed;
  logic [15:0] cur_ease;
  logic [31:0] cur_start, cur_ep;

  assign item_rdy_o = !mid_vld_r || mid_rdy_i;
  assign proc       = item_vld_i && item_rdy_o;
  assign idx        = AW'(item_i.axis);
  assign in_range   = int'(item_i.axis) < AXES;

  assign cur_armed = armed_r[idx];
  assign cur_ease  = ease_r[idx];
  assign cur_start = start_r[idx];
  assign cur_ep    = ep_r[idx];

  always_comb begin
    diff = $signed({item_i.feedback_position[31], item_i.feedback_position})
         - $signed({item_i.target_position[31], item_i.target_position});
    abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
    far = abs_diff > {3'b000, cfg_i.half_turn};
    if (!far) begin
      ep_wide = 34'(signed'(item_i.target_position));
    end else if (!diff[32]) begin
      ep_wide = 34'(signed'(item_i.target_position)) + $signed({4'b0000, cfg_i.full_turn});
    end else begin
      ep_wide = 34'(signed'(item_i.target_position)) - $signed({4'b0000, cfg_i.full_turn});
    end
    if (ep_wide > 34'sh0_7FFF_FFFF) begin
      ep_sat = 32'h7FFF_FFFF;
    end else if (ep_wide < -34'sh0_8000_0000) begin
      ep_sat = 32'h8000_0000;
    end else begin
      ep_sat = ep_wide[31:0];
    end

    elapsed   = item_i.now_ms - cur_start;
    timed_out = elapsed > cfg_i.timeout_ms;

    err = $signed({cur_ep[31], cur_ep})
        - $signed({item_i.feedback_position[31], item_i.feedback_position});
    abs_err = err[32] ? 33'(-err) : 33'(err);
    arrived = abs_err < {3'b000, cfg_i.arrive_eps};

    ease_sum = {1'b0, cur_ease} + {4'b0000, cfg_i.ease_step};
    if (cur_ease < cfg_i.ease_max) begin
      ease_new = ease_sum[16] ? EASE_SAT : ease_sum[15:0];
    end else begin
      ease_new = cur_ease;
    end

    mid_nxt.status    = ST_WORK;
    mid_nxt.cmd_valid = 1'b0;
    mid_nxt.is_move   = 1'b0;
    mid_nxt.fixed_pos = '0;
    mid_nxt.err       = err;
    mid_nxt.ease      = ease_new;
    mid_nxt.fb        = item_i.feedback_position;
    mid_nxt.node      = item_i.node_id;
    if (in_range && cur_armed) begin
      mid_nxt.cmd_valid = 1'b1;
      if (timed_out) begin
        mid_nxt.status    = ST_TIMEOUT;
        mid_nxt.fixed_pos = item_i.feedback_position;
      end else if (arrived) begin
        mid_nxt.status    = ST_DONE;
        mid_nxt.fixed_pos = item_i.feedback_position;
      end else begin
        mid_nxt.is_move = 1'b1;
      end
    end
  end

  // Armed flags are the only context state that needs a reset: the other
  // fields are written when an axis arms and are read only while armed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        armed_r[i] <= 1'b0;
      end
    end else if (proc && in_range) begin
      if (!cur_armed) begin
        armed_r[idx] <= 1'b1;
      end else if (timed_out || arrived) begin
        armed_r[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_range) begin
      if (!cur_armed) begin
        ease_r[idx]  <= '0;
        start_r[idx] <= item_i.now_ms;
        ep_r[idx]    <= ep_sat;
      end else if (!timed_out && !arrived) begin
        ease_r[idx] <= ease_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
    end else if (item_rdy_o) begin
      mid_vld_r <= item_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_vld_o = mid_vld_r;
  assign mid_o     = mid_r;

  a_quiet_is_working: assert property (@(posedge clk) disable iff (!rst_n)
    mid_vld_r && !mid_r.cmd_valid |-> mid_r.status == ST_WORK && !mid_r.is_move)
    else $error("result without command carries a nonzero status");

  a_finish_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_range && cur_armed && (timed_out || arrived) |=> !armed_r[$past(idx)])
    else $error("axis still armed after done or timeout");

  a_ease_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    proc && mid_nxt.is_move |=> ease_r[$past(idx)] >= $past(cur_ease))
    else $error("ease factor fell during an eased move");

endmodule

// ===== hw/rtl/eph_mul.sv =====
module eph_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mid_vld_i,
  input  eph_pkg::mid_t  mid_i,
  output logic           mid_rdy_o,
  output logic           prod_vld_o,
  output eph_pkg::prod_t prod_o,
  input  logic           prod_rdy_i
);
  import eph_pkg::*;

  logic  prod_vld_r;
  prod_t prod_r, prod_nxt;

  assign mid_rdy_o = !prod_vld_r || prod_rdy_i;

  always_comb begin
    prod_nxt.status    = mid_i.status;
    prod_nxt.cmd_valid = mid_i.cmd_valid;
    prod_nxt.is_move   = mid_i.is_move;
    prod_nxt.fixed_pos = mid_i.fixed_pos;
    prod_nxt.fb        = mid_i.fb;
    prod_nxt.node      = mid_i.node;
    // Signed error times unsigned Q0.16 ease, both widened to the full
    // product width before the multiply.
    prod_nxt.prod = PROD_W'($signed(mid_i.err)) * PROD_W'($signed({1'b0, mid_i.ease}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (mid_rdy_o) begin
      prod_vld_r <= mid_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_vld_i && mid_rdy_o) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_vld_o = prod_vld_r;
  assign prod_o     = prod_r;

endmodule

// ===== hw/rtl/eph_out.sv =====
module eph_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           prod_vld_i,
  input  eph_pkg::prod_t prod_i,
  output logic           prod_rdy_o,
  output logic           res_vld_o,
  output eph_pkg::res_t  res_o,
  input  logic           res_rdy_i
);
  import eph_pkg::*;

  logic               res_vld_r;
  res_t               res_r, res_nxt;
  logic signed [PROD_W-1:0] rnd;
  logic signed [34:0] sum;
  logic [31:0]        sat;

  assign prod_rdy_o = !res_vld_r || res_rdy_i;

  always_comb begin
    // Round half up, then drop the 16 fraction bits (arithmetic shift).
    rnd = $signed(prod_i.prod) + $signed(PROD_W'(32768));
    sum = 35'(signed'(prod_i.fb)) + 35'(signed'(rnd[PROD_W-1:16]));
    if (sum > 35'sh0_7FFF_FFFF) begin
      sat = 32'h7FFF_FFFF;
    end else if (sum < -35'sh0_8000_0000) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum[31:0];
    end
    res_nxt.status           = prod_i.status;
    res_nxt.command_valid    = prod_i.cmd_valid;
    res_nxt.command_position = prod_i.is_move ? sat : prod_i.fixed_pos;
    res_nxt.command_node     = prod_i.node;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (prod_rdy_o) begin
      res_vld_r <= prod_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_vld_i && prod_rdy_o) begin
      res_r <= res_nxt;
    end
  end

  assign res_vld_o = res_vld_r;
  assign res_o     = res_r;

endmodule

// ===== hw/rtl/eased_position_homing_unit.sv =====
// Eased position homing unit: one homing context per axis.
// Input channel (in_*): one transaction per control tick, carrying the axis,
// the node id, the encoder feedback, the target angle and a millisecond time.
// Result channel (out_*): exactly one transaction per input transaction, in
// order, with status, command valid flag, commanded position and node id.
// Configuration channel (cfg_*): writes one of six registers by index; it is
// always ready and is meant to be written only while no transaction is in
// flight. Indexes beyond the last register are accepted and ignored.
// Throughput: one transaction per cycle while out_tready stays high. Each item
// passes an input register, a decision stage that reads and updates the axis
// context, a multiply stage and an output register that drives out_tvalid.
// Context updates land in the decision stage, so back-to-back items for the
// same axis see each other's effect.
// Reset (rst_n low, synchronous) disarms every axis, empties the pipeline and
// loads the default register values.
// When the receiver stalls, each stage holds its item and keeps accepting
// until the stage after it is full; in_tready falls once all four stages hold
// an item, and no transaction is lost.
module eased_position_homing_unit #(
  parameter int AXES = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // axis[1:0], node_id[9:2], feedback_position[41:10],
  // target_position[73:42], now_ms[105:74], zero fill[111:106]
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], command_valid[2], command_position[34:3],
  // command_node[42:35], zero fill[47:43]
  output logic [47:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [eph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);
  import eph_pkg::*;

  cfg_t  cfg_r;
  logic  in_vld_r;
  item_t in_item_r;
  logic  ctx_rdy;
  logic  mid_vld, mid_rdy;
  mid_t  mid;
  logic  prod_vld, prod_rdy;
  prod_t prod;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_turn  <= RST_HALF_TURN;
      cfg_r.full_turn  <= RST_FULL_TURN;
      cfg_r.timeout_ms <= RST_TIMEOUT_MS;
      cfg_r.arrive_eps <= RST_ARRIVE_EPS;
      cfg_r.ease_max   <= RST_EASE_MAX;
      cfg_r.ease_step  <= RST_EASE_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HALF_TURN:  cfg_r.half_turn  <= cfg_data[29:0];
        CFG_FULL_TURN:  cfg_r.full_turn  <= cfg_data[29:0];
        CFG_TIMEOUT_MS: cfg_r.timeout_ms <= cfg_data;
        CFG_ARRIVE_EPS: cfg_r.arrive_eps <= cfg_data[29:0];
        CFG_EASE_MAX:   cfg_r.ease_max   <= cfg_data[15:0];
        CFG_EASE_STEP:  cfg_r.ease_step  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Input register.
  assign in_tready = !in_vld_r || ctx_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_tdata[105:0];
    end
  end

  eph_ctx #(
    .AXES(AXES)
  ) u_ctx (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .item_vld_i (in_vld_r),
    .item_i     (in_item_r),
    .item_rdy_o (ctx_rdy),
    .mid_vld_o  (mid_vld),
    .mid_o      (mid),
    .mid_rdy_i  (mid_rdy)
  );

  eph_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_vld_i  (mid_vld),
    .mid_i      (mid),
    .mid_rdy_o  (mid_rdy),
    .prod_vld_o (prod_vld),
    .prod_o     (prod),
    .prod_rdy_i (prod_rdy)
  );

  eph_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_vld_i (prod_vld),
    .prod_i     (prod),
    .prod_rdy_o (prod_rdy),
    .res_vld_o  (out_tvalid),
    .res_o      (res),
    .res_rdy_i  (out_tready)
  );

  assign out_tdata = {5'b00000, res};

endmodule
